// ----- rtl/window_size_hint_constrain_defines.svh -----
// ----------------------------------------------------------------------------
// Window size hint constrain assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef WINDOW_SIZE_HINT_CONSTRAIN_DEFINES_SVH
`define WINDOW_SIZE_HINT_CONSTRAIN_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define WSHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("window_size_hint_constrain: check failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define WSHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("window_size_hint_constrain: check failed");

`endif

// ----- rtl/wshc_pkg.sv -----
// ----------------------------------------------------------------------------
// Window size hint constrain package
// Field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package wshc_pkg;

  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;
  localparam int ASP_W     = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_W  = 3'd0,
    REG_BASE_H  = 3'd1,
    REG_MIN_W   = 3'd2,
    REG_MIN_H   = 3'd3,
    REG_MAX_W   = 3'd4,
    REG_MAX_H   = 3'd5,
    REG_STEP_W  = 3'd6,
    REG_STEP_H  = 3'd7
  } cfg_reg_t;

endpackage

// ----- rtl/wshc_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined two-lane divider
// Restoring long division, one quotient bit per register stage, with a
// payload and a valid bit carried alongside. The numerator shifted right by
// QW must be smaller than the divisor.
// ----------------------------------------------------------------------------
module wshc_div #(
  parameter int NW = 46,
  parameter int DW = 31,
  parameter int QW = 17,
  parameter int PW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num0_i,
  input  logic [NW-1:0] num1_i,
  input  logic [DW-1:0] den0_i,
  input  logic [DW-1:0] den1_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [QW-1:0] quo0_o,
  output logic [QW-1:0] quo1_o,
  output logic [DW-1:0] rem0_o,
  output logic [DW-1:0] rem1_o,
  output logic [PW-1:0] pay_o
);

  logic [DW-1:0] rem_r [2][QW+1];
  logic [QW-1:0] nq_r  [2][QW+1];
  logic [DW-1:0] den_r [2][QW+1];
  logic [PW-1:0] pay_r [QW+1];
  logic          valid_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en_i) begin
      valid_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      rem_r[0][0] <= DW'(num0_i >> QW);
      rem_r[1][0] <= DW'(num1_i >> QW);
      nq_r[0][0]  <= num0_i[QW-1:0];
      nq_r[1][0]  <= num1_i[QW-1:0];
      den_r[0][0] <= den0_i;
      den_r[1][0] <= den1_i;
      pay_r[0]    <= pay_i;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_r[s+1] <= valid_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en_i) begin
        pay_r[s+1] <= pay_r[s];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW:0] trial;
      logic        ge;

      assign trial = {rem_r[l][s], nq_r[l][s][QW-1]};
      assign ge    = trial >= {1'b0, den_r[l][s]};

      always_ff @(posedge clk) begin
        if (en_i) begin
          rem_r[l][s+1] <= ge ? DW'(trial - {1'b0, den_r[l][s]}) : trial[DW-1:0];
          nq_r[l][s+1]  <= {nq_r[l][s][QW-2:0], ge};
          den_r[l][s+1] <= den_r[l][s];
        end
      end
    end
  end

  assign valid_o = valid_r[QW];
  assign quo0_o  = nq_r[0][QW];
  assign quo1_o  = nq_r[1][QW];
  assign rem0_o  = rem_r[0][QW];
  assign rem1_o  = rem_r[1][QW];
  assign pay_o   = pay_r[QW];

endmodule

// ----- rtl/wshc_front.sv -----
// ----------------------------------------------------------------------------
// Aspect front end
// Five register stages: offsets from the base, ratio cross products, pair
// selection with the projection products, the projection sums, and the
// scaled numerators that feed the divider.
// ----------------------------------------------------------------------------
module wshc_front
  import wshc_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [DIM_BITS-1:0] req_w_i,
  input  logic signed [DIM_BITS-1:0] req_h_i,
  input  logic [ASP_W-1:0]           mnx_i,
  input  logic [ASP_W-1:0]           mny_i,
  input  logic [ASP_W-1:0]           mxx_i,
  input  logic [ASP_W-1:0]           mxy_i,
  input  logic [CFG_W-1:0]           base_w_i,
  input  logic [CFG_W-1:0]           base_h_i,
  output logic                       valid_o,
  output logic                       apply_o,
  output logic signed [DIM_BITS-1:0] w_o,
  output logic signed [DIM_BITS-1:0] h_o,
  output logic [DIM_BITS+29:0]       an_o,
  output logic [DIM_BITS+29:0]       bn_o,
  output logic [2*ASP_W:0]           d_o
);

  localparam int SW = ((DIM_BITS > CFG_W) ? DIM_BITS : CFG_W) + 2;
  localparam int XW = DIM_BITS - 1;
  localparam int PW = XW + ASP_W;
  localparam int NW = PW + 1;
  localparam int AW = DIM_BITS + 30;
  localparam int DW = 2 * ASP_W + 1;

  logic signed [SW-1:0] sdx, sdy;
  logic                 ok;

  assign sdx = SW'(req_w_i) - $signed(SW'(base_w_i));
  assign sdy = SW'(req_h_i) - $signed(SW'(base_h_i));
  assign ok  = (mnx_i != '0) && (mny_i != '0) && (mxx_i != '0) && (mxy_i != '0) &&
               (sdx > 0) && (sdy > 0);

  logic                       v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                       ok1_r, ok2_r, ap3_r, ap4_r, ap5_r;
  logic signed [DIM_BITS-1:0] w1_r, w2_r, w3_r, w4_r, w5_r;
  logic signed [DIM_BITS-1:0] h1_r, h2_r, h3_r, h4_r, h5_r;
  logic [XW-1:0]              dx1_r, dy1_r, dx2_r, dy2_r;
  logic [ASP_W-1:0]           mnx1_r, mny1_r, mxx1_r, mxy1_r;
  logic [ASP_W-1:0]           mnx2_r, mny2_r, mxx2_r, mxy2_r;
  logic [PW-1:0]              plo2_r, phi2_r, qlo2_r, qhi2_r;
  logic [ASP_W-1:0]           a3_r, b3_r, a4_r, b4_r;
  logic [PW-1:0]              dxa3_r, dyb3_r;
  logic [2*ASP_W-1:0]         aa3_r, bb3_r;
  logic [NW-1:0]              n4_r;
  logic [DW-1:0]              d4_r, d5_r;
  logic [AW-1:0]              an5_r, bn5_r;

  logic             below, above;
  logic [ASP_W-1:0] a_sel, b_sel;

  assign below = plo2_r < phi2_r;
  assign above = qlo2_r > qhi2_r;
  assign a_sel = below ? mnx2_r : mxx2_r;
  assign b_sel = below ? mny2_r : mxy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en_i) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      ok1_r  <= ok;
      w1_r   <= req_w_i;
      h1_r   <= req_h_i;
      dx1_r  <= sdx[XW-1:0];
      dy1_r  <= sdy[XW-1:0];
      mnx1_r <= mnx_i;
      mny1_r <= mny_i;
      mxx1_r <= mxx_i;
      mxy1_r <= mxy_i;

      ok2_r  <= ok1_r;
      w2_r   <= w1_r;
      h2_r   <= h1_r;
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
      mnx2_r <= mnx1_r;
      mny2_r <= mny1_r;
      mxx2_r <= mxx1_r;
      mxy2_r <= mxy1_r;
      plo2_r <= PW'(dx1_r) * PW'(mny1_r);
      phi2_r <= PW'(mnx1_r) * PW'(dy1_r);
      qlo2_r <= PW'(dx1_r) * PW'(mxy1_r);
      qhi2_r <= PW'(mxx1_r) * PW'(dy1_r);

      ap3_r  <= ok2_r && (below || above);
      w3_r   <= w2_r;
      h3_r   <= h2_r;
      a3_r   <= a_sel;
      b3_r   <= b_sel;
      dxa3_r <= PW'(dx2_r) * PW'(a_sel);
      dyb3_r <= PW'(dy2_r) * PW'(b_sel);
      aa3_r  <= (2*ASP_W)'(a_sel) * (2*ASP_W)'(a_sel);
      bb3_r  <= (2*ASP_W)'(b_sel) * (2*ASP_W)'(b_sel);

      ap4_r  <= ap3_r;
      w4_r   <= w3_r;
      h4_r   <= h3_r;
      a4_r   <= a3_r;
      b4_r   <= b3_r;
      n4_r   <= NW'(dxa3_r) + NW'(dyb3_r);
      d4_r   <= DW'(aa3_r) + DW'(bb3_r);

      ap5_r  <= ap4_r;
      w5_r   <= w4_r;
      h5_r   <= h4_r;
      d5_r   <= d4_r;
      an5_r  <= AW'(a4_r) * AW'(n4_r);
      bn5_r  <= AW'(b4_r) * AW'(n4_r);
    end
  end

  assign valid_o = v5_r;
  assign apply_o = ap5_r;
  assign w_o     = w5_r;
  assign h_o     = h5_r;
  assign an_o    = an5_r;
  assign bn_o    = bn5_r;
  assign d_o     = d5_r;

endmodule

// ----- rtl/window_size_hint_constrain.sv -----
// ----------------------------------------------------------------------------
// Window size hint constrain
// Fits a requested window size to aspect, minimum, maximum and increment
// hints, one request per word.
// ----------------------------------------------------------------------------
// The block takes one request word per clock cycle while in_tready is high
// and returns one result word for each, in order. It holds two
// bit-per-stage dividers: the aspect projection divider of DIM_BITS + 1
// stages and the increment remainder divider of WW stages, where WW is the
// wider of DIM_BITS and 16, plus three. The whole pipeline holds while a
// result word waits on out_tready.
module window_size_hint_constrain
  import wshc_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_addr,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // req_width, req_height, min_aspect_num, min_aspect_den, max_aspect_num,
  // max_aspect_den, zero fill.
  input  logic [((2*DIM_BITS+4*ASP_W+7)/8)*8-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // out_width, out_height, zero fill.
  output logic [((2*DIM_BITS+7)/8)*8-1:0] out_tdata
);

  localparam int OUT_TW = ((2*DIM_BITS+7)/8)*8;
  localparam int WW     = ((DIM_BITS > 16) ? DIM_BITS : 16) + 3;
  localparam int XW     = WW + 1;
  localparam int FW     = XW + 1;
  localparam int QA     = DIM_BITS + 1;
  localparam int NA     = DIM_BITS + 30;
  localparam int DA     = 2 * ASP_W + 1;
  localparam int PA     = 1 + 2 * DIM_BITS;
  localparam int PB     = 2 * WW + 2;
  localparam int A0     = 2 * DIM_BITS;

  logic [CFG_W-1:0] base_w_r, base_h_r, min_w_r, min_h_r;
  logic [CFG_W-1:0] max_w_r, max_h_r, step_w_r, step_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_w_r <= '0;
      base_h_r <= '0;
      min_w_r  <= '0;
      min_h_r  <= '0;
      max_w_r  <= '0;
      max_h_r  <= '0;
      step_w_r <= '0;
      step_h_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_BASE_W: base_w_r <= cfg_wdata;
        REG_BASE_H: base_h_r <= cfg_wdata;
        REG_MIN_W:  min_w_r  <= cfg_wdata;
        REG_MIN_H:  min_h_r  <= cfg_wdata;
        REG_MAX_W:  max_w_r  <= cfg_wdata;
        REG_MAX_H:  max_h_r  <= cfg_wdata;
        REG_STEP_W: step_w_r <= cfg_wdata;
        REG_STEP_H: step_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic                       fe_valid, fe_apply;
  logic signed [DIM_BITS-1:0] fe_w, fe_h;
  logic [NA-1:0]              fe_an, fe_bn;
  logic [DA-1:0]              fe_d;

  wshc_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en_i     (en),
    .valid_i  (in_tvalid),
    .req_w_i  (in_tdata[DIM_BITS-1:0]),
    .req_h_i  (in_tdata[2*DIM_BITS-1:DIM_BITS]),
    .mnx_i    (in_tdata[A0+ASP_W-1:A0]),
    .mny_i    (in_tdata[A0+2*ASP_W-1:A0+ASP_W]),
    .mxx_i    (in_tdata[A0+3*ASP_W-1:A0+2*ASP_W]),
    .mxy_i    (in_tdata[A0+4*ASP_W-1:A0+3*ASP_W]),
    .base_w_i (base_w_r),
    .base_h_i (base_h_r),
    .valid_o  (fe_valid),
    .apply_o  (fe_apply),
    .w_o      (fe_w),
    .h_o      (fe_h),
    .an_o     (fe_an),
    .bn_o     (fe_bn),
    .d_o      (fe_d)
  );

  logic          da_valid;
  logic [QA-1:0] da_q0, da_q1;
  logic [PA-1:0] da_pay;

  wshc_div #(.NW(NA), .DW(DA), .QW(QA), .PW(PA)) u_div_aspect (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (en),
    .valid_i (fe_valid),
    .num0_i  (fe_an),
    .num1_i  (fe_bn),
    .den0_i  (fe_d),
    .den1_i  (fe_d),
    .pay_i   ({fe_apply, fe_h, fe_w}),
    .valid_o (da_valid),
    .quo0_o  (da_q0),
    .quo1_o  (da_q1),
    .rem0_o  (),
    .rem1_o  (),
    .pay_o   (da_pay)
  );

  logic signed [WW-1:0] wc_nxt, hc_nxt;
  logic signed [XW-1:0] xw, xh;
  logic [WW-1:0]        xw_abs, xh_abs;

  always_comb begin
    if (da_pay[PA-1]) begin
      wc_nxt = $signed(WW'(da_q0)) + $signed(WW'(base_w_r));
      hc_nxt = $signed(WW'(da_q1)) + $signed(WW'(base_h_r));
    end else begin
      wc_nxt = WW'($signed(da_pay[DIM_BITS-1:0]));
      hc_nxt = WW'($signed(da_pay[2*DIM_BITS-1:DIM_BITS]));
    end
    if ((min_w_r != '0) && (wc_nxt < $signed(WW'(min_w_r)))) wc_nxt = $signed(WW'(min_w_r));
    if ((min_h_r != '0) && (hc_nxt < $signed(WW'(min_h_r)))) hc_nxt = $signed(WW'(min_h_r));
    if ((max_w_r != '0) && (wc_nxt > $signed(WW'(max_w_r)))) wc_nxt = $signed(WW'(max_w_r));
    if ((max_h_r != '0) && (hc_nxt > $signed(WW'(max_h_r)))) hc_nxt = $signed(WW'(max_h_r));
    xw     = XW'(wc_nxt) - $signed(XW'(base_w_r));
    xh     = XW'(hc_nxt) - $signed(XW'(base_h_r));
    xw_abs = xw[XW-1] ? WW'(-xw) : WW'(xw);
    xh_abs = xh[XW-1] ? WW'(-xh) : WW'(xh);
  end

  logic                 cl_valid_r;
  logic signed [WW-1:0] wc_r, hc_r;
  logic [WW-1:0]        xw_abs_r, xh_abs_r;
  logic                 xw_neg_r, xh_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_valid_r <= 1'b0;
    end else if (en) begin
      cl_valid_r <= da_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wc_r     <= wc_nxt;
      hc_r     <= hc_nxt;
      xw_abs_r <= xw_abs;
      xh_abs_r <= xh_abs;
      xw_neg_r <= xw[XW-1];
      xh_neg_r <= xh[XW-1];
    end
  end

  logic             db_valid;
  logic [CFG_W-1:0] db_rw, db_rh;
  logic [PB-1:0]    db_pay;

  wshc_div #(.NW(WW), .DW(CFG_W), .QW(WW), .PW(PB)) u_div_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (en),
    .valid_i (cl_valid_r),
    .num0_i  (xw_abs_r),
    .num1_i  (xh_abs_r),
    .den0_i  (step_w_r),
    .den1_i  (step_h_r),
    .pay_i   ({xh_neg_r, xw_neg_r, hc_r, wc_r}),
    .valid_o (db_valid),
    .quo0_o  (),
    .quo1_o  (),
    .rem0_o  (db_rw),
    .rem1_o  (db_rh),
    .pay_o   (db_pay)
  );

  logic signed [XW-1:0]       srw, srh;
  logic signed [FW-1:0]       wf, hf;
  logic signed [DIM_BITS-1:0] ow_nxt, oh_nxt;

  always_comb begin
    srw = db_pay[2*WW]   ? -$signed(XW'(db_rw)) : $signed(XW'(db_rw));
    srh = db_pay[2*WW+1] ? -$signed(XW'(db_rh)) : $signed(XW'(db_rh));
    wf  = FW'($signed(db_pay[WW-1:0]));
    hf  = FW'($signed(db_pay[2*WW-1:WW]));
    if (step_w_r != '0) wf = wf - FW'(srw);
    if (step_h_r != '0) hf = hf - FW'(srh);
    if (wf[FW-1:DIM_BITS-1] == '0 || wf[FW-1:DIM_BITS-1] == '1) begin
      ow_nxt = wf[DIM_BITS-1:0];
    end else begin
      ow_nxt = wf[FW-1] ? {1'b1, {(DIM_BITS-1){1'b0}}} : {1'b0, {(DIM_BITS-1){1'b1}}};
    end
    if (hf[FW-1:DIM_BITS-1] == '0 || hf[FW-1:DIM_BITS-1] == '1) begin
      oh_nxt = hf[DIM_BITS-1:0];
    end else begin
      oh_nxt = hf[FW-1] ? {1'b1, {(DIM_BITS-1){1'b0}}} : {1'b0, {(DIM_BITS-1){1'b1}}};
    end
  end

  logic [OUT_TW-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= db_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= OUT_TW'({oh_nxt, ow_nxt});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/wshc_checker.sv -----
// ----------------------------------------------------------------------------
// Window size hint constrain port checker
// Watches the top level ports for handshake and pipeline hold behavior.
// ----------------------------------------------------------------------------
`include "window_size_hint_constrain_defines.svh"

module wshc_checker #(
  parameter int DIM_BITS = 16
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [((2*DIM_BITS+7)/8)*8-1:0] out_tdata
);

  `WSHC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `WSHC_ASSERT_NOW(a_ready_free, !out_tvalid || out_tready, in_tready)
  `WSHC_ASSERT_NOW(a_ready_stall, !in_tready, out_tvalid && !out_tready)
  `WSHC_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_tvalid)

endmodule

bind window_size_hint_constrain wshc_checker #(.DIM_BITS(DIM_BITS)) u_wshc_checker (.*);

// ----- sim/window_size_hint_constrain_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Window size hint constrain testbench
// Drives request words with random gaps and checks every result word against
// a built-in predictor of the aspect, clamp and increment rules, across
// several register settings.
// ----------------------------------------------------------------------------
module window_size_hint_constrain_tb;
  import wshc_pkg::*;

  localparam int DIM_BITS = 16;
  localparam int IN_W = ((2*DIM_BITS+4*ASP_W+7)/8)*8;
  localparam int OUT_W = ((2*DIM_BITS+7)/8)*8;
  localparam int LATENCY = 60;

  typedef struct packed {
    logic [ASP_W-1:0] max_den;
    logic [ASP_W-1:0] max_num;
    logic [ASP_W-1:0] min_den;
    logic [ASP_W-1:0] min_num;
    logic signed [DIM_BITS-1:0] height;
    logic signed [DIM_BITS-1:0] width;
  } request_t;

  typedef struct packed {
    logic signed [DIM_BITS-1:0] height;
    logic signed [DIM_BITS-1:0] width;
  } size_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;

  longint hint_regs[8];
  request_t request_q[$];
  size_t size_q[$];
  int fail_count = 0;
  int in_gap = 0;
  int out_gap = 0;

  window_size_hint_constrain #(.DIM_BITS(DIM_BITS)) dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic longint saturate(longint v);
    longint hi;
    hi = (64'sd1 <<< (DIM_BITS-1)) - 1;
    if (v > hi) return hi;
    if (v < -hi-1) return -hi-1;
    return v;
  endfunction

  function automatic size_t constrain_size(request_t r);
    longint w, h, dx, dy, a, b, n, d;
    longint mnx, mny, mxx, mxy;
    size_t s;
    w = r.width;
    h = r.height;
    mnx = r.min_num; mny = r.min_den; mxx = r.max_num; mxy = r.max_den;
    dx = w - hint_regs[REG_BASE_W];
    dy = h - hint_regs[REG_BASE_H];
    if (mny > 0 && mxy > 0 && mnx > 0 && mxx > 0 && dx > 0 && dy > 0) begin
      a = 0;
      if (dx * mny < mnx * dy) begin
        a = mnx; b = mny;
      end else if (dx * mxy > mxx * dy) begin
        a = mxx; b = mxy;
      end
      if (a != 0) begin
        n = dx * a + dy * b;
        d = a * a + b * b;
        w = (a * n) / d + hint_regs[REG_BASE_W];
        h = (b * n) / d + hint_regs[REG_BASE_H];
      end
    end
    if (hint_regs[REG_MIN_W] != 0 && w < hint_regs[REG_MIN_W]) w = hint_regs[REG_MIN_W];
    if (hint_regs[REG_MIN_H] != 0 && h < hint_regs[REG_MIN_H]) h = hint_regs[REG_MIN_H];
    if (hint_regs[REG_MAX_W] != 0 && w > hint_regs[REG_MAX_W]) w = hint_regs[REG_MAX_W];
    if (hint_regs[REG_MAX_H] != 0 && h > hint_regs[REG_MAX_H]) h = hint_regs[REG_MAX_H];
    if (hint_regs[REG_STEP_W] != 0)
      w -= (w - hint_regs[REG_BASE_W]) % hint_regs[REG_STEP_W];
    if (hint_regs[REG_STEP_H] != 0)
      h -= (h - hint_regs[REG_BASE_H]) % hint_regs[REG_STEP_H];
    s.width = DIM_BITS'(saturate(w));
    s.height = DIM_BITS'(saturate(h));
    return s;
  endfunction

  // Driver: takes pending requests in order and predicts each as it is accepted.
  always @(posedge clk) begin
    int gap;
    if (in_tvalid && in_tready) begin
      size_q.push_back(constrain_size(request_t'(in_tdata[2*DIM_BITS+4*ASP_W-1:0])));
      void'(request_q.pop_front());
      gap = $urandom_range(0, 5);
      if (gap == 0 && request_q.size() > 0) begin
        in_tdata <= IN_W'(request_q[0]);
      end else begin
        in_gap <= (gap > 0) ? gap - 1 : 0;
        in_tvalid <= 0;
      end
    end else if (!in_tvalid && rst_n) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (request_q.size() > 0) begin
        in_tvalid <= 1;
        in_tdata <= IN_W'(request_q[0]);
      end
    end
  end

  // Monitor: random stalls and field compare against the oldest prediction.
  always @(posedge clk) begin
    size_t got, want;
    if (out_tvalid && out_tready) begin
      got = out_tdata[2*DIM_BITS-1:0];
      if (size_q.size() == 0) begin
        $error("unexpected result word %h", got);
        fail_count++;
      end else begin
        want = size_q.pop_front();
        if (got.width !== want.width) begin
          $error("out_width expected %0d actual %0d", want.width, got.width);
          fail_count++;
        end
        if (got.height !== want.height) begin
          $error("out_height expected %0d actual %0d", want.height, got.height);
          fail_count++;
        end
      end
      out_gap = $urandom_range(0, 5);
    end
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 0;
    end else begin
      out_tready <= rst_n;
    end
  end

  task automatic write_hint(cfg_reg_t idx, longint value);
    @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= CFG_W'(value);
    hint_regs[idx] = value;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain;
    while (request_q.size() > 0 || in_tvalid || size_q.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic longint pick_dim();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 40);
      2: return $urandom_range(0, 4000);
      3: return 32767 - $urandom_range(0, 100);
      4: return -32768 + $urandom_range(0, 100);
      default: return $urandom_range(0, 600);
    endcase
  endfunction

  function automatic longint pick_aspect();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return $urandom_range(1, 20);
      2: return $urandom_range(0, 32767);
      3: return 32767 - $urandom_range(0, 3);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  task automatic queue_request(longint w, longint h, longint a, longint b,
                               longint c, longint d);
    request_t r;
    r.width = DIM_BITS'(w); r.height = DIM_BITS'(h);
    r.min_num = ASP_W'(a); r.min_den = ASP_W'(b);
    r.max_num = ASP_W'(c); r.max_den = ASP_W'(d);
    request_q.push_back(r);
  endtask

  task automatic random_hints(int mode);
    cfg_reg_t idx;
    longint v;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_t'(i);
      case (mode)
        0: v = 0;
        1: v = 32767;
        default: begin
          case ($urandom_range(0, 3))
            0: v = 0;
            1: v = $urandom_range(1, 16);
            2: v = $urandom_range(0, 32767);
            default: v = $urandom_range(1, 800);
          endcase
        end
      endcase
      write_hint(idx, v);
    end
  endtask

  initial begin
    foreach (hint_regs[i]) hint_regs[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    // Directed: all hints off, then extremes and each aspect case.
    queue_request(32767, 32767, 32767, 32767, 32767, 32767);
    queue_request(-32768, -32768, 0, 0, 0, 0);
    queue_request(100, 100, 1, 2, 2, 1);
    queue_request(400, 100, 1, 2, 2, 1);
    queue_request(100, 400, 1, 2, 2, 1);
    queue_request(100, 400, 3, 1, 1, 3);
    queue_request(0, 50, 1, 1, 1, 1);
    queue_request(30000, 1, 32767, 1, 32767, 1);
    queue_request(1, 30000, 1, 32767, 1, 32767);
    queue_request(32767, 1, 1, 32767, 1, 32767);
    drain();
    write_hint(REG_BASE_W, 20); write_hint(REG_BASE_H, 10);
    write_hint(REG_MIN_W, 50); write_hint(REG_MIN_H, 40);
    write_hint(REG_MAX_W, 500); write_hint(REG_MAX_H, 300);
    write_hint(REG_STEP_W, 7); write_hint(REG_STEP_H, 32767);
    queue_request(5, 5, 0, 0, 0, 0);
    queue_request(1000, 1000, 1, 1, 1, 1);
    queue_request(-32768, 32767, 4, 3, 16, 9);
    queue_request(15, 300, 1, 1, 1, 1);
    queue_request(333, 222, 4, 3, 16, 9);
    drain();
    random_hints(1);
    queue_request(32767, 32767, 1, 1, 1, 1);
    queue_request(-32768, 0, 1, 1, 1, 1);
    queue_request(100, 100, 0, 0, 0, 0);
    drain();
    for (int phase = 0; phase < 12; phase++) begin
      random_hints(phase == 0 ? 0 : 2);
      for (int i = 0; i < 150; i++)
        queue_request(pick_dim(), pick_dim(), pick_aspect(), pick_aspect(),
                      pick_aspect(), pick_aspect());
      drain();
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule

// ----- window_size_hint_constrain.f -----
+incdir+rtl
rtl/wshc_pkg.sv
rtl/wshc_div.sv
rtl/wshc_front.sv
rtl/window_size_hint_constrain.sv
rtl/wshc_checker.sv
sim/window_size_hint_constrain_tb.sv
